// ===== hdl/pwc_pkg.sv =====
// pwc_pkg: item types, codes, channel state and tables for the pulse wave channel
// used by pulse_wave_channel_top; depends on nothing
`timescale 1ns / 1ps

package pwc_pkg;

    localparam logic [2:0] MODE_REG_WRITE    = 3'd0;
    localparam logic [2:0] MODE_TIMER_TICK   = 3'd1;
    localparam logic [2:0] MODE_QUARTER_TICK = 3'd2;
    localparam logic [2:0] MODE_HALF_TICK    = 3'd3;
    localparam logic [2:0] MODE_STATUS_WRITE = 3'd4;

    localparam logic [1:0] REG_CONTROL   = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_PERIOD_HI = 2'd3;

    localparam logic [3:0]  ENVELOPE_TOP   = 4'd15;
    localparam logic [15:0] PERIOD_MAX     = 16'h07FF;
    localparam logic [10:0] PERIOD_MIN     = 11'd8;
    localparam logic        NEGATE_DEFAULT = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0] level;
        logic       length_active;
        logic       sweep_muted;
    } out_item_t;

    typedef struct packed {
        logic        channel_enabled;
        logic [1:0]  duty_select;
        logic [2:0]  sequence_step;
        logic        halt_and_loop;
        logic        constant_volume;
        logic [3:0]  volume_value;
        logic        envelope_restart;
        logic [3:0]  envelope_divider;
        logic [3:0]  decay_level;
        logic        sweep_enable;
        logic [2:0]  sweep_rate;
        logic        sweep_negate;
        logic [2:0]  sweep_shift;
        logic        sweep_reload;
        logic [2:0]  sweep_divider;
        logic [10:0] period_value;
        logic [10:0] period_countdown;
        logic [7:0]  length_count;
    } state_t;

    localparam logic [7:0] LENGTH_LUT [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    localparam logic [7:0] DUTY_WAVES [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    // sweep target, 16 bits wide so that a negate below zero wraps high
    function automatic logic [15:0] sweep_target(input logic [10:0] period,
                                                 input logic [2:0]  shift,
                                                 input logic        negate,
                                                 input logic        first_neg);
        logic [15:0] p;
        logic [15:0] delta;
        p     = {5'd0, period};
        delta = p >> shift;
        if (negate)
            return p - delta - {15'd0, first_neg};
        else
            return p + delta;
    endfunction

    function automatic logic is_muted(input state_t s, input logic first_neg);
        return (s.period_value < PERIOD_MIN) ||
               (sweep_target(s.period_value, s.sweep_shift, s.sweep_negate,
                             first_neg) > PERIOD_MAX);
    endfunction

endpackage

// ===== hdl/pulse_wave_channel_top.sv =====
// pulse_wave_channel_top: square-wave channel with input item register and result register
// depends on pwc_pkg for item types, codes, state layout and tables
`timescale 1ns / 1ps

// an accepted item waits in the input register until the result register can take its result
// throughput: one item per cycle from the single update pass unless a full output stalls
// reset: all channel state cleared, first_neg_reg set to 1, both registers empty
// in_stall rises only when the input register is full and the result register cannot move
module pulse_wave_channel_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  pwc_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output pwc_pkg::out_item_t  out_item
);

    logic               first_neg_reg;
    logic               in_valid_reg;
    pwc_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    pwc_pkg::out_item_t out_item_reg;
    pwc_pkg::state_t    state_reg;
    pwc_pkg::state_t    state_next;
    pwc_pkg::out_item_t result_next;
    logic               advance;
    logic               take_in;
    logic [15:0]        target_now;
    logic               muted_now;
    logic               muted_after;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign target_now = pwc_pkg::sweep_target(state_reg.period_value, state_reg.sweep_shift,
                                              state_reg.sweep_negate, first_neg_reg);
    assign muted_now  = pwc_pkg::is_muted(state_reg, first_neg_reg);

    always_comb
    begin
        state_next = state_reg;
        case (in_item_reg.mode)
            pwc_pkg::MODE_REG_WRITE:
            begin
                case (in_item_reg.reg_index)
                    pwc_pkg::REG_CONTROL:
                    begin
                        state_next.duty_select     = in_item_reg.write_data[7:6];
                        state_next.halt_and_loop   = in_item_reg.write_data[5];
                        state_next.constant_volume = in_item_reg.write_data[4];
                        state_next.volume_value    = in_item_reg.write_data[3:0];
                    end
                    pwc_pkg::REG_SWEEP:
                    begin
                        state_next.sweep_enable = in_item_reg.write_data[7];
                        state_next.sweep_rate   = in_item_reg.write_data[6:4];
                        state_next.sweep_negate = in_item_reg.write_data[3];
                        state_next.sweep_shift  = in_item_reg.write_data[2:0];
                        state_next.sweep_reload = 1'b1;
                    end
                    pwc_pkg::REG_PERIOD_LO:
                    begin
                        state_next.period_value[7:0] = in_item_reg.write_data;
                    end
                    default:
                    begin
                        state_next.period_value[10:8] = in_item_reg.write_data[2:0];
                        if (state_reg.channel_enabled)
                            state_next.length_count =
                                pwc_pkg::LENGTH_LUT[in_item_reg.write_data[7:3]];
                        state_next.sequence_step    = 3'd0;
                        state_next.envelope_restart = 1'b1;
                    end
                endcase
            end
            pwc_pkg::MODE_TIMER_TICK:
            begin
                if (state_reg.period_countdown == 11'd0)
                begin
                    state_next.period_countdown = state_reg.period_value;
                    state_next.sequence_step    = state_reg.sequence_step + 3'd1;
                end
                else
                begin
                    state_next.period_countdown = state_reg.period_countdown - 11'd1;
                end
            end
            pwc_pkg::MODE_QUARTER_TICK:
            begin
                if (state_reg.envelope_restart)
                begin
                    state_next.envelope_restart = 1'b0;
                    state_next.decay_level      = pwc_pkg::ENVELOPE_TOP;
                    state_next.envelope_divider = state_reg.volume_value;
                end
                else if (state_reg.envelope_divider == 4'd0)
                begin
                    state_next.envelope_divider = state_reg.volume_value;
                    if (state_reg.decay_level != 4'd0)
                        state_next.decay_level = state_reg.decay_level - 4'd1;
                    else if (state_reg.halt_and_loop)
                        state_next.decay_level = pwc_pkg::ENVELOPE_TOP;
                end
                else
                begin
                    state_next.envelope_divider = state_reg.envelope_divider - 4'd1;
                end
            end
            pwc_pkg::MODE_HALF_TICK:
            begin
                if (!state_reg.halt_and_loop && state_reg.length_count != 8'd0)
                    state_next.length_count = state_reg.length_count - 8'd1;
                if (state_reg.sweep_divider == 3'd0 && state_reg.sweep_enable &&
                    state_reg.sweep_shift != 3'd0 && !muted_now)
                    state_next.period_value = target_now[10:0];
                if (state_reg.sweep_divider == 3'd0 || state_reg.sweep_reload)
                begin
                    state_next.sweep_divider = state_reg.sweep_rate;
                    state_next.sweep_reload  = 1'b0;
                end
                else
                begin
                    state_next.sweep_divider = state_reg.sweep_divider - 3'd1;
                end
            end
            pwc_pkg::MODE_STATUS_WRITE:
            begin
                state_next.channel_enabled = in_item_reg.write_data[0];
                if (!in_item_reg.write_data[0])
                    state_next.length_count = 8'd0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // result reflects the state after the item
    always_comb
    begin
        muted_after               = pwc_pkg::is_muted(state_next, first_neg_reg);
        result_next.sweep_muted   = muted_after;
        result_next.length_active = (state_next.length_count != 8'd0);
        result_next.level         = 4'd0;
        if (state_next.channel_enabled && state_next.length_count != 8'd0 && !muted_after &&
            pwc_pkg::DUTY_WAVES[state_next.duty_select][state_next.sequence_step])
            result_next.level = state_next.constant_volume ? state_next.volume_value
                                                           : state_next.decay_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_neg_reg <= pwc_pkg::NEGATE_DEFAULT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
                first_neg_reg <= cfg_data;
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result_next;
    end

endmodule
